// ===== sv/tie_pkg.sv =====
// Package with the shared types, codes and sizes of the execute unit.
package tie_pkg;

    localparam int REG_COUNT  = 16;
    localparam int MEM_DEPTH  = 128;
    localparam int PROG_DEPTH = 128;
    localparam int WORD_BITS  = 32;
    localparam int REG_AW     = $clog2(REG_COUNT);
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int PC_W       = $clog2(PROG_DEPTH);
    localparam int CNT_W      = $clog2(WORD_BITS + 1);

    typedef logic [WORD_BITS-1:0] t_word;

    localparam logic [4:0] OP_RET    = 5'd0;
    localparam logic [4:0] OP_PRINT  = 5'd1;
    localparam logic [4:0] OP_BPRINT = 5'd2;
    localparam logic [4:0] OP_CMP    = 5'd3;
    localparam logic [4:0] OP_JMP    = 5'd4;
    localparam logic [4:0] OP_JLE    = 5'd10;
    localparam logic [4:0] OP_CMOV   = 5'd11;
    localparam logic [4:0] OP_CMOVLE = 5'd17;
    localparam logic [4:0] OP_NEG    = 5'd18;
    localparam logic [4:0] OP_ADD    = 5'd19;
    localparam logic [4:0] OP_SUB    = 5'd20;
    localparam logic [4:0] OP_MUL    = 5'd21;
    localparam logic [4:0] OP_DIV    = 5'd22;
    localparam logic [4:0] OP_MOD    = 5'd23;
    localparam logic [4:0] OP_XOR    = 5'd24;
    localparam logic [4:0] OP_OR     = 5'd25;
    localparam logic [4:0] OP_AND    = 5'd26;
    localparam logic [4:0] OP_TEST   = 5'd27;
    localparam logic [4:0] OP_SAL    = 5'd28;
    localparam logic [4:0] OP_SAR    = 5'd29;
    localparam logic [4:0] OP_SHR    = 5'd30;

    localparam logic [1:0] K_IMM = 2'd0;
    localparam logic [1:0] K_REG = 2'd1;

    localparam logic [2:0] E_NONE = 3'd0;
    localparam logic [2:0] E_IMM  = 3'd1;
    localparam logic [2:0] E_MEM  = 3'd2;
    localparam logic [2:0] E_DIV0 = 3'd3;
    localparam logic [2:0] E_JUMP = 3'd4;

    typedef struct packed {
        logic  start;
        logic  is_div;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quotient;
        t_word remainder;
    } t_div_rsp;

endpackage

// ===== sv/tie_divider.sv =====
// Restoring signed divider, one quotient bit per cycle.
module tie_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tie_pkg::t_div_req i_req,
    output tie_pkg::t_div_rsp o_rsp
);
    import tie_pkg::*;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_quo;
    t_word            r_rem;
    t_word            r_div;
    logic             r_qneg;
    logic             r_rneg;
    logic             r_done;
    logic [WORD_BITS:0] w_trial;
    t_word            w_rem_sh;

    assign w_rem_sh = {r_rem[WORD_BITS-2:0], r_quo[WORD_BITS-1]};
    assign w_trial  = {1'b0, w_rem_sh} - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WORD_BITS);
                r_quo  <= i_req.dividend[WORD_BITS-1] ? -i_req.dividend : i_req.dividend;
                r_div  <= i_req.divisor[WORD_BITS-1] ? -i_req.divisor : i_req.divisor;
                r_rem  <= '0;
                r_qneg <= i_req.dividend[WORD_BITS-1] ^ i_req.divisor[WORD_BITS-1];
                r_rneg <= i_req.dividend[WORD_BITS-1];
            end else if (r_busy) begin
                // The remainder can carry one bit beyond the word for the most negative value.
                if (!w_trial[WORD_BITS] || r_rem[WORD_BITS-1]) begin
                    r_rem <= w_trial[WORD_BITS-1:0];
                    r_quo <= {r_quo[WORD_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_quo <= {r_quo[WORD_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_qneg ? -r_quo : r_quo;
    assign o_rsp.remainder = r_rneg ? -r_rem : r_rem;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start) else $error("divider restarted while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider busy at done");
`endif

endmodule

// ===== sv/toy_isa_execute_unit.sv =====
// Top level of the toy instruction set execute unit.
// Executes one instruction per input word and returns one result word per
// instruction. Registers and data memory live in three synchronous RAMs (two
// register file copies and the data memory), so an instruction passes through
// register read, source memory read, destination memory read and execute with
// write back before its result; a conditional move into memory adds a memory
// write step, and divide or remainder wait for the bit-serial divider. One
// instruction is in flight at a time. After reset a clearing pass writes zero
// to every register and memory word while no instruction word is taken.
module toy_isa_execute_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: req_type[4:0], src_kind[6:5], src_value[38:7], dst_kind[40:39], dst_value[72:41]
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: shown_kind[1:0], shown_value[33:2], next_pc[40:34], halted[41], error[44:42]
    output logic [47:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_data
);
    import tie_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_RREG   = 9'b000000100,
        S_RMEM   = 9'b000001000,
        S_EXEC   = 9'b000010000,
        S_DADDR  = 9'b000100000,
        S_DWAIT  = 9'b001000000,
        S_DIV    = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state r_state;
    logic [MEM_AW-1:0] r_clr;
    logic [7:0]  r_plen;
    logic [PC_W-1:0] r_pc;
    logic r_zf, r_sf, r_of;
    logic [4:0] r_op;
    logic [1:0] r_sk, r_dk;
    logic [31:0] r_sv, r_dv;
    t_word r_x, r_y;
    t_word r_sreg, r_dreg;

    // register file: two read ports via two copies written together
    t_word rf_a [REG_COUNT];
    t_word rf_b [REG_COUNT];
    t_word r_rfa, r_rfb;
    logic  rf_we;
    logic [REG_AW-1:0] rf_wa, rf_ra, rf_rb;
    t_word rf_wd;

    t_word dm [MEM_DEPTH];
    t_word r_dmq;
    logic  dm_we;
    logic [MEM_AW-1:0] dm_wa, dm_ra;
    t_word dm_wd;

    logic [MEM_AW-1:0] r_daddr;
    logic [1:0]  r_okind;
    t_word r_oval;
    logic [PC_W-1:0] r_onext;
    logic r_ohalt;
    logic [2:0] r_oerr;

    t_div_req div_req;
    t_div_rsp div_rsp;

    tie_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf_a[rf_wa] <= rf_wd;
            rf_b[rf_wa] <= rf_wd;
        end
        r_rfa <= rf_a[rf_ra];
        r_rfb <= rf_b[rf_rb];
    end

    always_ff @(posedge i_clk) begin
        if (dm_we) dm[dm_wa] <= dm_wd;
        r_dmq <= dm[dm_ra];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {3'b0, r_oerr, r_ohalt, r_onext, r_oval, r_okind};

    function automatic t_word f_imm(input logic [31:0] v);
        return t_word'($signed(v));
    endfunction

    // condition select from flags
    function automatic logic f_cond(input logic [2:0] sel, input logic zf,
                                    input logic sf, input logic of_);
        logic lt;
        lt = sf ^ of_;
        case (sel)
            3'd0: return 1'b1;
            3'd1: return zf;
            3'd2: return !zf;
            3'd3: return !lt && !zf;
            3'd4: return !lt;
            3'd5: return lt;
            default: return lt || zf;
        endcase
    endfunction

    logic  w_is_jmp, w_is_cmov, w_cond;
    logic [4:0] w_sel5;
    t_word w_alu, w_neg_b, w_t;
    logic  w_big;
    t_word w_prod;

    assign w_is_jmp  = (r_op >= OP_JMP) && (r_op <= OP_JLE);
    assign w_is_cmov = (r_op >= OP_CMOV) && (r_op <= OP_CMOVLE);
    assign w_sel5    = w_is_jmp ? r_op - OP_JMP : r_op - OP_CMOV;
    assign w_cond    = f_cond(w_sel5[2:0], r_zf, r_sf, r_of);
    assign w_neg_b   = -r_y;
    assign w_t       = r_x + w_neg_b;
    assign w_big     = (r_x >= t_word'(WORD_BITS));
    assign w_prod    = r_dreg * r_x;

    always_comb begin
        case (r_op)
            OP_ADD: w_alu = r_dreg + r_x;
            OP_SUB: w_alu = r_dreg - r_x;
            OP_MUL: w_alu = w_prod;
            OP_XOR: w_alu = r_dreg ^ r_x;
            OP_OR:  w_alu = r_dreg | r_x;
            OP_AND: w_alu = r_dreg & r_x;
            OP_SAL: w_alu = w_big ? '0 : r_dreg << r_x[CNT_W-1:0];
            OP_SHR: w_alu = w_big ? '0 : r_dreg >> r_x[CNT_W-1:0];
            OP_SAR: w_alu = w_big ? {WORD_BITS{r_dreg[WORD_BITS-1]}}
                                  : t_word'($signed(r_dreg) >>> r_x[CNT_W-1:0]);
            default: w_alu = r_dreg;
        endcase
    end

    // Read addresses, write port controls and the divider request.
    always_comb begin
        rf_we = 1'b0; rf_wa = r_dv[REG_AW-1:0]; rf_wd = '0;
        dm_we = 1'b0; dm_wa = r_daddr; dm_wd = r_x;
        rf_ra = r_sv[REG_AW-1:0];
        rf_rb = r_dv[REG_AW-1:0];
        dm_ra = r_rfa[MEM_AW-1:0];
        div_req.start    = 1'b0;
        div_req.is_div   = (r_op == OP_DIV);
        div_req.dividend = r_dreg;
        div_req.divisor  = r_x;
        if (r_state == S_CLEAR) begin
            rf_we = 1'b1; rf_wa = r_clr[REG_AW-1:0];
            dm_we = 1'b1; dm_wa = r_clr; dm_wd = '0;
        end else if (r_state == S_IDLE) begin
            rf_ra = s_axis_tdata[7+:REG_AW];
            rf_rb = s_axis_tdata[41+:REG_AW];
        end else if (r_state == S_RMEM) begin
            // The source word is already in hand; fetch the destination word.
            dm_ra = r_rfb[MEM_AW-1:0];
        end else if (r_state == S_DADDR) begin
            dm_ra = r_rfb[MEM_AW-1:0];
        end else if (r_state == S_EXEC) begin
            if (w_is_cmov && w_cond && r_dk == K_REG) begin
                rf_we = 1'b1; rf_wd = r_x;
            end else if (r_op == OP_NEG && r_sk == K_REG) begin
                rf_we = 1'b1; rf_wa = r_sv[REG_AW-1:0]; rf_wd = -r_sreg;
            end else if (r_op >= OP_ADD && r_op <= OP_SHR && r_op != OP_TEST
                         && r_op != OP_DIV && r_op != OP_MOD && r_dk == K_REG) begin
                rf_we = 1'b1; rf_wd = w_alu;
            end else if ((r_op == OP_DIV || r_op == OP_MOD) && r_dk == K_REG
                         && r_x != '0) begin
                div_req.start = 1'b1;
            end
        end else if (r_state == S_DWAIT) begin
            dm_we = 1'b1;
        end else if (r_state == S_DIV && div_rsp.done) begin
            rf_we = 1'b1;
            rf_wd = (r_op == OP_DIV) ? div_rsp.quotient : div_rsp.remainder;
        end
    end

    logic [PC_W-1:0] w_pc1;
    assign w_pc1 = r_pc + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_plen  <= '0;
            r_pc    <= '0;
            r_zf    <= 1'b0;
            r_sf    <= 1'b0;
            r_of    <= 1'b0;
        end else begin
            if (i_cfg_valid) r_plen <= i_cfg_data;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == MEM_AW'(MEM_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op <= s_axis_tdata[4:0];
                        r_sk <= s_axis_tdata[6:5];
                        r_sv <= s_axis_tdata[38:7];
                        r_dk <= s_axis_tdata[40:39];
                        r_dv <= s_axis_tdata[72:41];
                        r_state <= S_RREG;
                    end
                end
                S_RREG: r_state <= S_RMEM;
                S_RMEM: begin
                    r_sreg <= r_rfa;
                    r_dreg <= r_rfb;
                    r_x <= (r_sk == K_IMM) ? f_imm(r_sv) : (r_sk == K_REG) ? r_rfa : r_dmq;
                    r_daddr <= r_rfb[MEM_AW-1:0];
                    r_state <= S_DADDR;
                end
                S_DADDR: r_state <= S_EXEC;
                S_EXEC: begin
                    r_okind <= '0; r_oval <= '0; r_ohalt <= 1'b0; r_oerr <= E_NONE;
                    r_onext <= w_pc1;
                    r_state <= S_OUT;
                    if (r_op == OP_RET) begin
                        r_ohalt <= 1'b1; r_onext <= r_pc;
                    end else if (r_op == OP_PRINT || r_op == OP_BPRINT) begin
                        r_okind <= r_op[1:0]; r_oval <= r_x; r_pc <= w_pc1;
                    end else if (r_op == OP_CMP) begin
                        r_zf <= (w_t == '0);
                        r_sf <= w_t[WORD_BITS-1];
                        r_of <= (r_x[WORD_BITS-1] == w_neg_b[WORD_BITS-1])
                                && (w_t[WORD_BITS-1] != r_x[WORD_BITS-1]);
                        r_pc <= w_pc1;
                    end else if (r_op == OP_TEST) begin
                        r_zf <= ((r_x & r_y) == '0); r_sf <= 1'b0; r_of <= 1'b0;
                        r_pc <= w_pc1;
                    end else if (w_is_jmp) begin
                        if (w_cond) begin
                            if (r_sv[31] || r_sv >= {24'b0, r_plen} || r_sv >= 32'(PROG_DEPTH)) begin
                                r_oerr <= E_JUMP; r_onext <= r_pc;
                            end else begin
                                r_onext <= r_sv[PC_W-1:0]; r_pc <= r_sv[PC_W-1:0];
                            end
                        end else r_pc <= w_pc1;
                    end else if (w_is_cmov) begin
                        if (w_cond && r_dk == K_IMM) begin
                            r_oerr <= E_IMM; r_onext <= r_pc;
                        end else begin
                            r_pc <= w_pc1;
                            if (w_cond && r_dk != K_REG) r_state <= S_DWAIT;
                        end
                    end else if (r_op == OP_NEG) begin
                        if (r_sk != K_IMM && r_sk != K_REG) begin
                            r_oerr <= E_MEM; r_onext <= r_pc;
                        end else r_pc <= w_pc1;
                    end else if (r_op >= OP_ADD && r_op <= OP_SHR) begin
                        if (r_dk == K_IMM) begin
                            r_oerr <= E_IMM; r_onext <= r_pc;
                        end else if (r_dk != K_REG) begin
                            r_oerr <= E_MEM; r_onext <= r_pc;
                        end else if ((r_op == OP_DIV || r_op == OP_MOD) && r_x == '0) begin
                            r_oerr <= E_DIV0; r_onext <= r_pc;
                        end else begin
                            r_pc <= w_pc1;
                            if (r_op == OP_DIV || r_op == OP_MOD) r_state <= S_DIV;
                        end
                    end else r_pc <= w_pc1;
                end
                S_DWAIT: r_state <= S_OUT;
                S_DIV: if (div_rsp.done) r_state <= S_OUT;
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // second operand value, taken once the destination memory word is read
    always_ff @(posedge i_clk) begin
        if (r_state == S_DADDR)
            r_y <= (r_dk == K_IMM) ? f_imm(r_dv) : (r_dk == K_REG) ? r_dreg : r_dmq;
    end

    logic w_unused;
    assign w_unused = ^{s_axis_tdata[79:73], div_req.is_div, rf_ra, rf_rb};

`ifndef SYNTHESIS
    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");
    a_err_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_oerr != E_NONE |-> r_onext == r_pc)
        else $error("error moved the pc");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accepted while result pending");
`endif

endmodule

// ===== test/tb_toy_isa_execute_unit.sv =====
// Testbench for the execute unit: random and directed instructions checked against a predictor.
module tb_toy_isa_execute_unit;
    import tie_pkg::*;

    localparam logic [4:0] OP_JE     = 5'd5;
    localparam logic [4:0] OP_JNE    = 5'd6;
    localparam logic [4:0] OP_JG     = 5'd7;
    localparam logic [4:0] OP_JL     = 5'd9;
    localparam logic [4:0] OP_CMOVE  = 5'd12;
    localparam logic [4:0] OP_CMOVNE = 5'd13;
    localparam logic [4:0] OP_UNUSED = 5'd31;
    localparam logic [1:0] K_MEM     = 2'd2;
    localparam logic [1:0] K_ALT     = 2'd3;
    localparam int         IDLE_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;

    toy_isa_execute_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Machine state as the predictor sees it.
    t_word             arch_reg [REG_COUNT];
    t_word             arch_mem [MEM_DEPTH];
    logic              flag_z, flag_s, flag_o;
    logic [PC_W-1:0]   arch_pc;
    logic [7:0]        prog_len;

    logic [79:0] instr_q [$];
    logic [47:0] result_q [$];
    int          fails = 0;
    int          accepted = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    bit          hold_done = 0;
    int          idle_cycles = 0;

    function automatic logic [79:0] pack_instr(logic [4:0] op, logic [1:0] sk, t_word sv,
                                               logic [1:0] dk, t_word dv);
        return {7'd0, dv, dk, sv, sk, op};
    endfunction

    function automatic t_word operand(logic [1:0] kind, t_word raw);
        if (kind == K_IMM) return raw;
        if (kind == K_REG) return arch_reg[raw[REG_AW-1:0]];
        return arch_mem[arch_reg[raw[REG_AW-1:0]][MEM_AW-1:0]];
    endfunction

    function automatic bit cond_true(logic [2:0] sel);
        logic lt;
        lt = flag_s != flag_o;
        case (sel)
            3'd0: return 1'b1;
            3'd1: return flag_z;
            3'd2: return !flag_z;
            3'd3: return !lt && !flag_z;
            3'd4: return !lt;
            3'd5: return lt;
            default: return lt || flag_z;
        endcase
    endfunction

    // Executes one instruction on the predictor state and returns the result word.
    function automatic logic [47:0] execute_instr(logic [79:0] d);
        logic [4:0]      op;
        logic [1:0]      sk, dk, shown_k;
        t_word           sv, dv, x, y, b, t, res, shown_v, ay, ax, q;
        logic [PC_W-1:0] nxt;
        logic            halt;
        logic [2:0]      err;
        logic [REG_AW-1:0] r;
        op = d[4:0]; sk = d[6:5]; sv = d[38:7]; dk = d[40:39]; dv = d[72:41];
        shown_k = 2'd0; shown_v = '0; halt = 1'b0; err = E_NONE;
        nxt = arch_pc + 1'b1;
        if (op == OP_RET) begin
            halt = 1'b1;
            nxt = arch_pc;
        end else if (op == OP_PRINT || op == OP_BPRINT) begin
            shown_k = op[1:0];
            shown_v = operand(sk, sv);
        end else if (op == OP_CMP || op == OP_TEST) begin
            x = operand(sk, sv);
            y = operand(dk, dv);
            if (op == OP_CMP) begin
                b = -y;
                t = x + b;
                flag_z = t == '0;
                flag_s = t[WORD_BITS-1];
                flag_o = (x[WORD_BITS-1] == b[WORD_BITS-1]) && (t[WORD_BITS-1] != x[WORD_BITS-1]);
            end else begin
                flag_z = (x & y) == '0;
                flag_s = 1'b0;
                flag_o = 1'b0;
            end
        end else if (op >= OP_JMP && op <= OP_JLE) begin
            if (cond_true(3'(op - OP_JMP))) begin
                if (sv[31] || sv >= prog_len || sv >= PROG_DEPTH) err = E_JUMP;
                else nxt = sv[PC_W-1:0];
            end
        end else if (op >= OP_CMOV && op <= OP_CMOVLE) begin
            if (cond_true(3'(op - OP_CMOV))) begin
                x = operand(sk, sv);
                if (dk == K_IMM) err = E_IMM;
                else if (dk == K_REG) arch_reg[dv[REG_AW-1:0]] = x;
                else arch_mem[arch_reg[dv[REG_AW-1:0]][MEM_AW-1:0]] = x;
            end
        end else if (op == OP_NEG) begin
            if (sk == K_REG) arch_reg[sv[REG_AW-1:0]] = -arch_reg[sv[REG_AW-1:0]];
            else if (sk != K_IMM) err = E_MEM;
        end else if (op >= OP_ADD && op <= OP_SHR) begin
            if (dk == K_IMM) err = E_IMM;
            else if (dk != K_REG) err = E_MEM;
            else begin
                x = operand(sk, sv);
                r = dv[REG_AW-1:0];
                y = arch_reg[r];
                res = y;
                case (op)
                    OP_ADD: res = y + x;
                    OP_SUB: res = y - x;
                    OP_MUL: res = y * x;
                    OP_DIV, OP_MOD: begin
                        if (x == '0) err = E_DIV0;
                        else begin
                            ay = y[31] ? -y : y;
                            ax = x[31] ? -x : x;
                            if (op == OP_DIV) begin
                                q = ay / ax;
                                res = (y[31] ^ x[31]) ? -q : q;
                            end else begin
                                q = ay % ax;
                                res = y[31] ? -q : q;
                            end
                        end
                    end
                    OP_XOR: res = y ^ x;
                    OP_OR:  res = y | x;
                    OP_AND: res = y & x;
                    OP_SAL: res = (x >= WORD_BITS) ? '0 : (y << x);
                    OP_SHR: res = (x >= WORD_BITS) ? '0 : (y >> x);
                    OP_SAR: res = (x >= WORD_BITS) ? {WORD_BITS{y[31]}} : t_word'($signed(y) >>> x);
                    default: res = y;
                endcase
                if (err == E_NONE) arch_reg[r] = res;
            end
        end
        if (err != E_NONE) nxt = arch_pc;
        arch_pc = nxt;
        return {3'd0, err, halt, nxt, shown_v, shown_k};
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("result %0d: %s is %h, predicted %h", accepted, field, got, want);
        fails++;
    endtask

    function automatic t_word pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return '0;
            4, 5: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [79:0] random_instr();
        logic [4:0] op;
        logic [1:0] sk, dk;
        t_word      sv, dv;
        op = ($urandom_range(0, 99) < 2) ? OP_RET : 5'($urandom_range(1, 31));
        sk = ($urandom_range(0, 9) == 0) ? K_ALT : 2'($urandom_range(0, 2));
        dk = ($urandom_range(0, 9) < 7) ? K_REG : 2'($urandom_range(0, 3));
        sv = (sk == K_IMM) ? pick_value() : $urandom;
        dv = $urandom;
        if (op >= OP_JMP && op <= OP_JLE)
            sv = ($urandom_range(0, 4) == 0) ? pick_value() : $urandom_range(0, prog_len + 3);
        if ((op == OP_SAL || op == OP_SAR || op == OP_SHR) && sk == K_IMM && $urandom_range(0, 1))
            sv = $urandom_range(0, 40);
        // Now and then give a conditional move a memory destination.
        if ((op >= OP_CMOV && op <= OP_CMOVLE) && $urandom_range(0, 2) == 0) dk = K_MEM;
        return pack_instr(op, sk, sv, dk, dv);
    endfunction

    task automatic write_length(logic [7:0] len);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (instr_q.size() != 0 || result_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Sender: bursts of words with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (instr_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= instr_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern that steps through four modes, plus one long hold-off.
    int rx_cycle = 0;
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (!hold_done && accepted == 400) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_cycle[8:7])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= $urandom_range(0, 3) != 0;
                2'd2: m_axis_tready <= rx_cycle[2:0] != 3'd0;
                default: m_axis_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    // Input side: predict every accepted word; configuration writes update the length.
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) prog_len = i_cfg_data;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) result_q.push_back(execute_instr(s_axis_tdata));
    end

    // Output side: compare each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin
        logic [47:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            accepted++;
            if (result_q.size() == 0) begin
                $display("result %0d arrived with nothing predicted", accepted);
                fails++;
            end else begin
                want = result_q.pop_front();
                if (m_axis_tdata[1:0] != want[1:0])
                    report("shown_kind", m_axis_tdata[1:0], want[1:0]);
                if (m_axis_tdata[33:2] != want[33:2])
                    report("shown_value", m_axis_tdata[33:2], want[33:2]);
                if (m_axis_tdata[40:34] != want[40:34])
                    report("next_pc", m_axis_tdata[40:34], want[40:34]);
                if (m_axis_tdata[41] != want[41])
                    report("halted", m_axis_tdata[41], want[41]);
                if (m_axis_tdata[44:42] != want[44:42])
                    report("error", m_axis_tdata[44:42], want[44:42]);
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        logic [7:0] lengths [5];
        lengths = '{8'd10, 8'd128, 8'd255, 8'd0, 8'd37};
        foreach (arch_reg[i]) arch_reg[i] = '0;
        foreach (arch_mem[i]) arch_mem[i] = '0;
        flag_z = 0; flag_s = 0; flag_o = 0;
        arch_pc = '0;
        prog_len = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_length(lengths[0]);

        // Directed: extremes, error codes, flag logic, memory paths.
        instr_q.push_back(pack_instr(OP_PRINT, K_IMM, 32'h7fff_ffff, K_IMM, '0));
        instr_q.push_back(pack_instr(OP_BPRINT, K_IMM, 32'h8000_0000, K_IMM, '0));
        instr_q.push_back(pack_instr(OP_CMOV, K_IMM, 32'h8000_0000, K_REG, 32'hffff_fff1));
        instr_q.push_back(pack_instr(OP_CMOV, K_IMM, 32'hffff_ffff, K_REG, 32'd2));
        instr_q.push_back(pack_instr(OP_DIV, K_REG, 32'd2, K_REG, 32'd1));
        instr_q.push_back(pack_instr(OP_MOD, K_REG, 32'd2, K_REG, 32'd1));
        instr_q.push_back(pack_instr(OP_DIV, K_IMM, 32'd0, K_REG, 32'd2));
        instr_q.push_back(pack_instr(OP_ADD, K_IMM, 32'd5, K_IMM, 32'd2));
        instr_q.push_back(pack_instr(OP_ADD, K_IMM, 32'd5, K_MEM, 32'd2));
        instr_q.push_back(pack_instr(OP_NEG, K_REG, 32'd2, K_IMM, '0));
        instr_q.push_back(pack_instr(OP_NEG, K_MEM, 32'd2, K_IMM, '0));
        instr_q.push_back(pack_instr(OP_NEG, K_IMM, 32'd2, K_IMM, '0));
        instr_q.push_back(pack_instr(OP_CMP, K_REG, 32'd1, K_IMM, 32'd1));
        instr_q.push_back(pack_instr(OP_JL, K_IMM, 32'd3, K_IMM, '0));
        instr_q.push_back(pack_instr(OP_JMP, K_IMM, 32'd10, K_IMM, '0));
        instr_q.push_back(pack_instr(OP_JMP, K_IMM, 32'hffff_fffe, K_IMM, '0));
        instr_q.push_back(pack_instr(OP_TEST, K_IMM, 32'h0f0f_0f0f, K_REG, 32'd1));
        instr_q.push_back(pack_instr(OP_JNE, K_IMM, 32'd9, K_IMM, '0));
        instr_q.push_back(pack_instr(OP_SAL, K_IMM, 32'd31, K_REG, 32'd2));
        instr_q.push_back(pack_instr(OP_SAR, K_IMM, 32'hffff_ffff, K_REG, 32'd1));
        instr_q.push_back(pack_instr(OP_SHR, K_IMM, 32'd32, K_REG, 32'd2));
        instr_q.push_back(pack_instr(OP_CMOVNE, K_IMM, 32'hdead_beef, K_MEM, 32'd1));
        instr_q.push_back(pack_instr(OP_PRINT, K_ALT, 32'd1, K_IMM, '0));
        instr_q.push_back(pack_instr(OP_RET, K_IMM, '0, K_IMM, '0));
        instr_q.push_back(pack_instr(OP_UNUSED, K_IMM, '0, K_IMM, '0));
        drain();

        for (int ph = 1; ph < 6; ph++) begin
            write_length(lengths[ph % 5]);
            for (int n = 0; n < 250; n++) instr_q.push_back(random_instr());
            drain();
        end

        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== toy_isa_execute_unit.f =====
sv/tie_pkg.sv
sv/tie_divider.sv
sv/toy_isa_execute_unit.sv
test/tb_toy_isa_execute_unit.sv
